// ===== design/volume_mip_downsample_max_avg_macros.svh =====
// ----------------------------------------------------------------------------
// volume_mip_downsample_max_avg assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOLUME_MIP_DOWNSAMPLE_MAX_AVG_MACROS_SVH
`define VOLUME_MIP_DOWNSAMPLE_MAX_AVG_MACROS_SVH

`ifndef SYNTHESIS
`define VMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VMD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMD_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/vmd_pkg.sv =====
// ----------------------------------------------------------------------------
// vmd_pkg
// Shared types and constants of the volume mip downsampler.
// ----------------------------------------------------------------------------
package vmd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ACC_W       = 37;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int LG_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

    localparam logic [LG_W-1:0] SRC_LOG2_RST = 3'd7;
    localparam logic [LG_W-1:0] DST_LOG2_RST = 3'd6;

    typedef enum logic [0:0] {
        RM_MAX = 1'b0,
        RM_AVG = 1'b1
    } t_reduce_mode;

    // clamped log2 edge, holds up to 15
    typedef logic [3:0] t_lg;

    typedef struct packed {
        logic first;
        logic last;
        logic last_vol;
    } t_pos_flags;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   last_vol;
    } t_result;

endpackage

// ===== design/vmd_in_if.sv =====
// ----------------------------------------------------------------------------
// vmd_in_if
// Source voxel channel: valid/ready with one sample per item.
// ----------------------------------------------------------------------------
interface vmd_in_if;
    import vmd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/vmd_out_if.sv =====
// ----------------------------------------------------------------------------
// vmd_out_if
// Result channel: valid/ready with one reduced voxel per item.
// ----------------------------------------------------------------------------
interface vmd_out_if;
    import vmd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] reduced_value;
    logic                   last_of_volume;

    modport source (output valid, output reduced_value, output last_of_volume, input ready);
    modport sink   (input valid, input reduced_value, input last_of_volume, output ready);
endinterface

// ===== design/volume_mip_downsample_max_avg.sv =====
// ----------------------------------------------------------------------------
// volume_mip_downsample_max_avg
// 3-D box-filter mipmap downsampler, block maximum or truncated block average.
// ----------------------------------------------------------------------------
// Takes one source voxel per cycle while the result queue has room. Each voxel
// does one read-modify-write of its destination column accumulator in a RAM
// of MAX_DEST_EDGE^2 entries: read issued on the accept cycle, update and write
// back on the next, with the previous write forwarded when both hit the same
// column. A result is pushed from the update stage into a two-entry queue
// and waits there. Accumulators need no clearing after reset; the first voxel
// of each block loads its accumulator. A write to the source size, destination
// size or mode register restarts the volume at voxel zero.
`include "volume_mip_downsample_max_avg_macros.svh"

module volume_mip_downsample_max_avg #(
    parameter int MAX_SOURCE_EDGE = 128,
    parameter int MAX_DEST_EDGE   = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vmd_in_if.sink                         i_src,
    vmd_out_if.source                      o_dst
);
    import vmd_pkg::*;

    localparam int SRC_LG = $clog2(MAX_SOURCE_EDGE + 1) - 1;
    localparam int DST_LG = $clog2(MAX_DEST_EDGE + 1) - 1;
    localparam int PW     = (SRC_LG > 0) ? SRC_LG : 1;
    localparam int DEPTH  = MAX_DEST_EDGE * MAX_DEST_EDGE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LG_W-1:0] r_src_lg;
    logic [LG_W-1:0] r_dst_lg;
    t_reduce_mode    r_mode;
    logic            restart;

    t_lg             slg, dlg, k;
    logic [4:0]      sh;
    logic            enable;
    logic            accept;
    logic [AW-1:0]   rd_addr;
    t_pos_flags      flags;

    logic                   r_s1_valid;
    logic [AW-1:0]          r_s1_addr;
    t_pos_flags             r_s1_flags;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic                   r_fwd;
    logic [ACC_W-1:0]       r_wr_data;

    logic [ACC_W-1:0] ram_rdata;
    logic [ACC_W-1:0] acc_old;
    logic [ACC_W-1:0] acc_new;
    logic [ACC_W-1:0] smp_ext;
    logic [ACC_W-1:0] avg_val;
    logic             push;
    t_result          res;
    t_result          q_data;
    logic             q_valid;
    logic [1:0]       q_count;

    // configuration
    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_LOG2: restart = 1'b1;
                CFG_DST_LOG2: restart = 1'b1;
                CFG_MODE:     restart = 1'b1;
                default:      restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_lg <= SRC_LOG2_RST;
            r_dst_lg <= DST_LOG2_RST;
            r_mode   <= RM_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_LOG2: r_src_lg <= i_cfg_data;
                CFG_DST_LOG2: r_dst_lg <= i_cfg_data;
                CFG_MODE:     r_mode   <= t_reduce_mode'(i_cfg_data[0]);
                default:      r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        slg = (t_lg'(r_src_lg) > t_lg'(SRC_LG)) ? t_lg'(SRC_LG) : t_lg'(r_src_lg);
        dlg = (t_lg'(r_dst_lg) > t_lg'(DST_LG)) ? t_lg'(DST_LG) : t_lg'(r_dst_lg);
        k   = slg - dlg;
        sh  = (5'(k) << 1) + 5'(k);
    end

    // stage 0: position, address, accumulator read
    assign accept = i_src.valid && i_src.ready;
    assign i_src.ready = (3'(q_count) + 3'(push)) < 3'd2;

    vmd_pos #(
        .PW (PW),
        .AW (AW)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (accept),
        .i_restart (restart),
        .i_slg     (slg),
        .i_dlg     (dlg),
        .o_enable  (enable),
        .o_addr    (rd_addr),
        .o_flags   (flags)
    );

    vmd_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (acc_new),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept && enable;
            r_fwd      <= accept && enable && r_s1_valid && (r_s1_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr   <= rd_addr;
            r_s1_flags  <= flags;
            r_s1_sample <= i_src.sample;
        end
        r_wr_data <= acc_new;
    end

    // stage 1: update and write back
    always_comb begin
        acc_old = r_fwd ? r_wr_data : ram_rdata;
        smp_ext = ACC_W'(r_s1_sample);
        priority if (r_s1_flags.first) begin
            acc_new = smp_ext;
        end else if (r_mode == RM_AVG) begin
            acc_new = acc_old + smp_ext;
        end else begin
            acc_new = (smp_ext > acc_old) ? smp_ext : acc_old;
        end
        avg_val      = acc_new >> sh;
        res.value    = (r_mode == RM_AVG) ? avg_val[SAMPLE_BITS-1:0]
                                          : acc_new[SAMPLE_BITS-1:0];
        res.last_vol = r_s1_flags.last_vol;
        push         = r_s1_valid && r_s1_flags.last;
    end

    vmd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_pop   (o_dst.valid && o_dst.ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_dst.valid          = q_valid;
    assign o_dst.reduced_value  = q_data.value;
    assign o_dst.last_of_volume = q_data.last_vol;

    `VMD_ASSERT(a_fwd_src, i_clk, i_rst_n, r_fwd |-> (r_s1_valid && $past(r_s1_valid)), "forward without a prior write")
    `VMD_ASSERT(a_lastvol_is_last, i_clk, i_rst_n, (r_s1_valid && r_s1_flags.last_vol) |-> push, "volume end without a result")
endmodule

// ===== design/vmd_ram.sv =====
// ----------------------------------------------------------------------------
// vmd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/vmd_pos.sv =====
// ----------------------------------------------------------------------------
// vmd_pos
// Source raster position counters, accumulator address and block flags.
// ----------------------------------------------------------------------------
module vmd_pos #(
    parameter int PW = 7,
    parameter int AW = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_restart,
    input  vmd_pkg::t_lg        i_slg,
    input  vmd_pkg::t_lg        i_dlg,
    output logic                o_enable,
    output logic [AW-1:0]       o_addr,
    output vmd_pkg::t_pos_flags o_flags
);
    import vmd_pkg::*;

    logic [PW-1:0] r_x, r_y, r_z;
    logic [PW-1:0] n_x, n_y, n_z;
    logic [PW-1:0] edge_m1;
    logic [PW-1:0] rmask;
    logic [PW-1:0] xs, ys;
    logic [31:0]   idx_w;
    t_lg           k;

    always_comb begin
        edge_m1  = PW'(((PW+1)'(1) << i_slg) - (PW+1)'(1));
        o_enable = i_dlg < i_slg;
        k        = i_slg - i_dlg;
        rmask    = PW'(((PW+1)'(1) << k) - (PW+1)'(1));
        xs       = r_x >> k;
        ys       = r_y >> k;
        idx_w    = (32'(ys) << i_dlg) | 32'(xs);
        o_addr   = idx_w[AW-1:0];

        o_flags.first    = ((r_x & rmask) == '0) && ((r_y & rmask) == '0)
                        && ((r_z & rmask) == '0);
        o_flags.last     = ((r_x & rmask) == rmask) && ((r_y & rmask) == rmask)
                        && ((r_z & rmask) == rmask);
        o_flags.last_vol = (r_x == edge_m1) && (r_y == edge_m1) && (r_z == edge_m1);
    end

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        priority if (i_restart) begin
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end else if (i_adv) begin
            if (r_x == edge_m1) begin
                n_x = '0;
                if (r_y == edge_m1) begin
                    n_y = '0;
                    n_z = (r_z == edge_m1) ? '0 : r_z + PW'(1);
                end else begin
                    n_y = r_y + PW'(1);
                end
            end else begin
                n_x = r_x + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end
endmodule

// ===== design/vmd_outq.sv =====
// ----------------------------------------------------------------------------
// vmd_outq
// Two-entry result queue between the accumulate stage and the output channel.
// ----------------------------------------------------------------------------
`include "volume_mip_downsample_max_avg_macros.svh"

module vmd_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vmd_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output vmd_pkg::t_result o_data,
    output logic [1:0]       o_count
);
    import vmd_pkg::*;

    t_result    r_mem [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    `VMD_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop && (r_cnt == 2'd2), "result queue overflow")
    `VMD_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "result queue count out of range")
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3-D mip downsampler: streams voxel cubes of
// several sizes in max and average mode, folds each accepted voxel into a
// local copy of the column accumulators, and compares every reduced voxel
// in order against the predicted one under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vmd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_DEST_EDGE = 64;
    localparam int MAX_DST_LG    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vmd_in_if  src_if ();
    vmd_out_if dst_if ();

    volume_mip_downsample_max_avg dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_src       (src_if),
        .o_dst       (dst_if)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // local copy of the block state
    logic [ACC_W-1:0] acc_mem [MAX_DEST_EDGE*MAX_DEST_EDGE];
    int unsigned      pos_x, pos_y, pos_z;
    logic [LG_W-1:0]  cur_src_lg = SRC_LOG2_RST;
    logic [LG_W-1:0]  cur_dst_lg = DST_LOG2_RST;
    t_reduce_mode     cur_mode   = RM_MAX;

    t_result     reduced_voxel_q [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 22;
    int unsigned dst_idle_pct = 76;
    int unsigned hold_req  = 0;
    int unsigned hold_left = 0;

    function automatic void fold_voxel(input logic [SAMPLE_BITS-1:0] smp);
        int unsigned      slg, dlg, span, k, rmask, col;
        logic [ACC_W-1:0] acc;
        logic             first_vox, last_vox;
        t_result          res;
        slg  = cur_src_lg;
        dlg  = (cur_dst_lg > MAX_DST_LG) ? MAX_DST_LG : cur_dst_lg;
        span = 1 << slg;
        if (dlg < slg) begin
            k         = slg - dlg;
            rmask     = (1 << k) - 1;
            col       = ((pos_y >> k) << dlg) + (pos_x >> k);
            first_vox = ((pos_x & rmask) == 0) && ((pos_y & rmask) == 0)
                        && ((pos_z & rmask) == 0);
            last_vox  = ((pos_x & rmask) == rmask) && ((pos_y & rmask) == rmask)
                        && ((pos_z & rmask) == rmask);
            acc = acc_mem[col];
            if (first_vox) begin
                acc = ACC_W'(smp);
            end else if (cur_mode == RM_AVG) begin
                acc = acc + ACC_W'(smp);
            end else if (ACC_W'(smp) > acc) begin
                acc = ACC_W'(smp);
            end
            acc_mem[col] = acc;
            if (last_vox) begin
                res.value    = (cur_mode == RM_AVG) ? SAMPLE_BITS'(acc >> (3 * k))
                                                    : SAMPLE_BITS'(acc);
                res.last_vol = (pos_x == span - 1) && (pos_y == span - 1)
                               && (pos_z == span - 1);
                reduced_voxel_q.push_back(res);
            end
        end
        pos_x++;
        if (pos_x >= span) begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= span) begin
                pos_y = 0;
                pos_z++;
                if (pos_z >= span) begin
                    pos_z = 0;
                end
            end
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return SAMPLE_BITS'($urandom_range(15));
            3: return ~SAMPLE_BITS'($urandom_range(15));
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // called on a falling edge, returns on a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_SRC_LOG2: cur_src_lg = data;
            CFG_DST_LOG2: cur_dst_lg = data;
            CFG_MODE:     cur_mode   = t_reduce_mode'(data[0]);
            default: ;
        endcase
        if (idx != CFG_NONE) begin
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_volume(input logic [LG_W-1:0] src_lg,
                                  input logic [LG_W-1:0] dst_lg,
                                  input logic [CFG_DATA_W-1:0] mode);
        write_reg(CFG_SRC_LOG2, src_lg);
        write_reg(CFG_DST_LOG2, dst_lg);
        write_reg(CFG_MODE, mode);
    endtask

    task automatic send_voxel(input logic [SAMPLE_BITS-1:0] smp);
        while ($urandom_range(99) < src_idle_pct) begin
            src_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        src_if.valid  <= 1'b1;
        src_if.sample <= smp;
        do @(posedge i_clk); while (!src_if.ready);
        fold_voxel(smp);
        @(negedge i_clk);
    endtask

    task automatic await_results();
        src_if.valid <= 1'b0;
        while (reduced_voxel_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_voxel('1);
        send_voxel('0);
        await_results();
    endtask

    task automatic test_block_extremes();
        program_volume(3'd1, 3'd0, CFG_DATA_W'(RM_MAX));
        send_voxel('0);
        send_voxel(16'h8000);
        send_voxel('1);
        send_voxel(16'h0001);
        repeat (4) send_voxel(16'h7FFF);
        await_results();
        program_volume(3'd1, 3'd0, CFG_DATA_W'(RM_AVG));
        repeat (7) send_voxel('1);
        send_voxel(16'hFFFE);
        await_results();
    endtask

    task automatic test_no_reduction();
        program_volume(3'd2, 3'd2, CFG_DATA_W'(RM_AVG));
        repeat (3) send_voxel(random_sample());
        await_results();
        write_reg(CFG_DST_LOG2, 3'd7);
        repeat (3) send_voxel(random_sample());
        await_results();
        program_volume(3'd0, 3'd0, CFG_DATA_W'(RM_MAX));
        repeat (2) send_voxel(random_sample());
        await_results();
    endtask

    task automatic test_config_restart();
        program_volume(3'd2, 3'd1, CFG_DATA_W'(RM_MAX));
        repeat (40) send_voxel(random_sample());
        await_results();
        write_reg(CFG_NONE, CFG_DATA_W'($urandom()));
        repeat (24) send_voxel(random_sample());
        await_results();
        repeat (20) send_voxel(random_sample());
        await_results();
        write_reg(CFG_MODE, CFG_DATA_W'(RM_AVG));
        repeat (64) send_voxel(random_sample());
        await_results();
    endtask

    task automatic test_output_backpressure();
        int unsigned saved_idle;
        saved_idle   = src_idle_pct;
        src_idle_pct = 0;
        program_volume(3'd1, 3'd0, CFG_DATA_W'(RM_AVG));
        hold_req = HOLD_CYCLES;
        repeat (160) send_voxel(random_sample());
        await_results();
        src_idle_pct = saved_idle;
    endtask

    // two full source rows of the largest cube; no block completes yet
    task automatic test_large_volume();
        program_volume(3'd7, 3'd7, CFG_DATA_W'(RM_AVG));
        repeat (2 << 7) send_voxel(random_sample());
        await_results();
    endtask

    task automatic test_random_volumes(input int unsigned budget);
        int unsigned counted, n, s_lg, d_lg, vol, pick;
        counted = 0;
        while (counted < budget) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                s_lg = 0;
            end else if (pick < 35) begin
                s_lg = 1;
            end else if (pick < 75) begin
                s_lg = 2;
            end else if (pick < 95) begin
                s_lg = 3;
            end else begin
                s_lg = 4;
            end
            if (s_lg == 0 || $urandom_range(9) == 0) begin
                d_lg = $urandom_range(7, s_lg);
            end else begin
                d_lg = $urandom_range(s_lg - 1, 0);
            end
            if ($urandom_range(7) == 0) begin
                write_reg(CFG_NONE, CFG_DATA_W'($urandom()));
            end
            program_volume(LG_W'(s_lg), LG_W'(d_lg), CFG_DATA_W'($urandom()));
            vol = 1 << (3 * s_lg);
            if (s_lg == 0) begin
                n = $urandom_range(4, 1);
            end else if (s_lg == 4) begin
                n = $urandom_range(700, 280);
            end else if ($urandom_range(4) == 0) begin
                n = $urandom_range(vol, 1);
            end else begin
                n = vol * $urandom_range(2, 1);
            end
            repeat (n) begin
                if ($urandom_range(299) == 0) begin
                    await_results();
                end
                send_voxel(random_sample());
            end
            await_results();
            if (d_lg < s_lg) begin
                counted += n;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            dst_if.ready <= 1'b0;
        end else begin
            dst_if.ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && dst_if.valid && dst_if.ready) begin
            if (reduced_voxel_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual value %0d last %0b",
                         $time, dst_if.reduced_value, dst_if.last_of_volume);
                mismatches++;
            end else begin
                want = reduced_voxel_q.pop_front();
                if (want.value !== dst_if.reduced_value) begin
                    $display("%0t: reduced_value expected %0d actual %0d",
                             $time, want.value, dst_if.reduced_value);
                    mismatches++;
                end
                if (want.last_vol !== dst_if.last_of_volume) begin
                    $display("%0t: last_of_volume expected %0b actual %0b",
                             $time, want.last_vol, dst_if.last_of_volume);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d items pending",
                     $time, reduced_voxel_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_if.valid  = 1'b0;
        src_if.sample = '0;
        dst_if.ready  = 1'b0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_block_extremes();
        test_no_reduction();
        test_config_restart();
        test_output_backpressure();
        test_large_volume();
        test_random_volumes(200);
        src_idle_pct = 76;
        dst_idle_pct = 22;
        test_random_volumes(200);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_volumes(200);

        await_results();
        if (mismatches == 0 && reduced_voxel_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/vmd_pkg.sv
design/vmd_in_if.sv
design/vmd_out_if.sv
design/vmd_ram.sv
design/vmd_pos.sv
design/vmd_outq.sv
design/volume_mip_downsample_max_avg.sv
tb/tb_top.sv
